[hw/rtl/npls_pkg.sv]
// npls_pkg: shared widths, codes and payload types for the nearest point to line selector.
// Used by the digit-serial multiplier, the divider and the top level.
// No dependencies.
package npls_pkg;

  // Field widths
  localparam int CoordW   = 24;             // signed Q11.12 coordinate
  localparam int DiffW    = CoordW + 1;     // exact coordinate difference
  localparam int FracW    = 12;             // fraction bits of a coordinate
  localparam int DistW    = 40;             // Q.12 squared distance
  localparam int IdxW     = 8;              // reported run position
  localparam int CfgIdxW  = 3;              // register index
  localparam int CfgDataW = DistW;          // widest register

  // Datapath widths
  localparam int MagW     = 2 * DiffW;      // |cross component| and line length squared
  localparam int LenW     = MagW;           // sum of squared line differences
  localparam int DenW     = LenW + FracW;   // divisor L * 4096
  localparam int NumW     = DenW + DistW;   // numerator as the divider sees it
  localparam int ProdW    = 2 * MagW;       // one full product
  localparam int AccW     = NumW + 2;       // signed accumulator

  // Digit-serial multiplier
  localparam int DigitW      = 16;
  localparam int ShortDigits = (DiffW + DigitW - 1) / DigitW;
  localparam int LongDigits  = (MagW + DigitW - 1) / DigitW;
  localparam int ShortBW     = ShortDigits * DigitW;
  localparam int MulBW       = LongDigits * DigitW;
  localparam int DigCntW     = $clog2(LongDigits + 1);

  // Run limits and constants
  localparam int MaxCandidates = 256;
  localparam logic [DistW-1:0] ThresholdReset = DistW'(100 * (1 << FracW));
  localparam logic [DistW-1:0] DistMax        = {DistW{1'b1}};

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgEndAX, CfgEndAY, CfgEndAZ, CfgEndBX, CfgEndBY, CfgEndBZ, CfgThreshold
  } cfg_reg_e;

  // Multiplier operations of one candidate, in issue order
  typedef enum logic [3:0] {
    OpLenX, OpLenY, OpLenZ,
    OpCxPos, OpCxNeg, OpCyPos, OpCyNeg, OpCzPos, OpCzNeg,
    OpSqX, OpSqY, OpSqZ
  } op_e;

  // Multiplier command
  typedef struct packed {
    logic                start;
    op_e                 tag;
    logic [MagW-1:0]     a;
    logic [MulBW-1:0]    b;       // left aligned, consumed MSB digit first
    logic [DigCntW-1:0]  digits;
    logic                neg;
    logic                clear;   // start a new sum with this product
  } mac_cmd_t;

  // Multiplier status
  typedef struct packed {
    logic ready;
    logic done;                   // accumulator holds the sum after tag
    op_e  tag;
  } mac_stat_t;

  // Channel payloads
  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic                     last_point;
  } point_t;

  typedef struct packed {
    logic [IdxW-1:0]  best_index;
    logic             found;
    logic [DistW-1:0] best_distance_sq;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

endpackage

[hw/rtl/npls_stream_if.sv]
// npls_stream_if: valid/ready channel carrying one payload per transaction.
// Payload type is set per instance; no other dependencies.
interface npls_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/npls_mac.sv]
// npls_mac: digit-serial multiply-accumulate, one 16-bit digit of b per cycle, MSB first.
// The finished product is folded into a signed accumulator while the next one starts.
// Depends on npls_pkg.
module npls_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  npls_pkg::mac_cmd_t                 cmd,
  output npls_pkg::mac_stat_t                stat,
  output logic signed [npls_pkg::AccW-1:0]   acc
);

  logic [npls_pkg::DigCntW-1:0]             steps;
  logic                                     fold;
  logic                                     done;
  logic [npls_pkg::MagW-1:0]                a_op;
  logic [npls_pkg::MulBW-1:0]               b_sh;
  logic                                     first;
  logic                                     neg;
  logic                                     clear;
  npls_pkg::op_e                            tag;
  logic                                     fold_neg;
  logic                                     fold_clear;
  npls_pkg::op_e                            fold_tag;
  npls_pkg::op_e                            done_tag;
  logic [npls_pkg::ProdW-1:0]               prod;
  logic [npls_pkg::MagW+npls_pkg::DigitW-1:0] partial;
  logic [npls_pkg::ProdW-1:0]               prod_next;
  logic signed [npls_pkg::AccW-1:0]         prod_ext;
  logic signed [npls_pkg::AccW-1:0]         term;

  // One digit partial product, Horner step
  assign partial   = a_op * b_sh[npls_pkg::MulBW-1 -: npls_pkg::DigitW];
  assign prod_next = (first ? '0 : (prod << npls_pkg::DigitW)) + npls_pkg::ProdW'(partial);

  // Signed term for the fold
  assign prod_ext = $signed(npls_pkg::AccW'(prod));
  assign term     = fold_neg ? -prod_ext : prod_ext;

  assign stat.ready = (steps == '0);
  assign stat.done  = done;
  assign stat.tag   = done_tag;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      fold  <= 1'b0;
      done  <= 1'b0;
    end else begin
      fold <= (steps == npls_pkg::DigCntW'(1));
      done <= fold;
      if (cmd.start) begin
        steps <= cmd.digits;
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
      end
    end
  end

  // Operands, product and accumulator
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_op  <= cmd.a;
      b_sh  <= cmd.b;
      first <= 1'b1;
      neg   <= cmd.neg;
      clear <= cmd.clear;
      tag   <= cmd.tag;
    end else if (steps != '0) begin
      prod  <= prod_next;
      b_sh  <= b_sh << npls_pkg::DigitW;
      first <= 1'b0;
    end
    if (steps == npls_pkg::DigCntW'(1)) begin
      fold_neg   <= neg;
      fold_clear <= clear;
      fold_tag   <= tag;
    end
    if (fold) begin
      acc      <= (fold_clear ? '0 : acc) + term;
      done_tag <= fold_tag;
    end
  end

endmodule

[hw/rtl/npls_div.sv]
// npls_div: bit-serial restoring divider, floor(num / (den * 4096)) saturated to 40 bits.
// One quotient bit per cycle after a saturation test made at start. Depends on npls_pkg.
module npls_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [npls_pkg::NumW-1:0]    num,
  input  logic [npls_pkg::LenW-1:0]    den,
  output logic                         done,
  output logic [npls_pkg::DistW-1:0]   quot
);

  localparam int QCntW = $clog2(npls_pkg::DistW + 1);
  localparam logic [QCntW-1:0] QSteps = QCntW'(npls_pkg::DistW);

  logic [QCntW-1:0]            cnt;
  logic [npls_pkg::DenW-1:0]   rem;
  logic [npls_pkg::DistW-1:0]  num_sh;
  logic [npls_pkg::DenW-1:0]   den_r;
  logic [npls_pkg::DenW-1:0]   num_hi;
  logic [npls_pkg::DenW-1:0]   den_m;
  logic                        sat;
  logic [npls_pkg::DenW:0]     trial;
  logic [npls_pkg::DenW:0]     diff;
  logic                        ge;

  // Quotient reaches 2^40 exactly when the top part already covers the divisor;
  // a zero divisor saturates the same way
  assign num_hi = num[npls_pkg::NumW-1 -: npls_pkg::DenW];
  assign den_m  = {den, {npls_pkg::FracW{1'b0}}};
  assign sat    = (num_hi >= den_m);

  // Restoring step
  assign trial = {rem, num_sh[npls_pkg::DistW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt  <= sat ? '0 : QSteps;
        done <= sat;
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == QCntW'(1));
      end
    end
  end

  // Remainder, numerator bits and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= num_hi;
      num_sh <= num[npls_pkg::DistW-1:0];
      den_r  <= den_m;
      if (sat) begin
        quot <= npls_pkg::DistMax;
      end
    end else if (cnt != '0) begin
      rem    <= ge ? diff[npls_pkg::DenW-1:0] : trial[npls_pkg::DenW-1:0];
      num_sh <= num_sh << 1;
      quot   <= {quot[npls_pkg::DistW-2:0], ge};
    end
  end

endmodule

[hw/rtl/nearest_point_to_line_select.sv]
// Nearest point to line selector. Two configured points A and B define a line; candidates
// stream in and each gets the squared distance |(P-A) x (P-B)|^2 / |A-B|^2 in Q.12, truncated
// and saturated to 2^40-1 (a zero-length line always saturates). The first candidate of a run
// latches the threshold; a candidate replaces the running best only if strictly smaller. The
// candidate marked last_point closes the run and produces one result transaction; others
// produce none. Candidates past MAX_CANDIDATES in a run are counted out and not compared.
// A computed candidate occupies the block from acceptance until it is done: the 16-bit-digit
// multiplier computes the line length, the three cross components and their squares, then the
// bit-serial divider produces the 40 quotient bits. A quotient that saturates (a zero-length
// line included) is settled when the divider starts, with no bit steps. A candidate past the
// limit skips both. The result sits in an output register, so a new run may start while it
// waits. Configuration is written with ready always high; the block has no clearing pass.
// Depends on npls_pkg, npls_stream_if, npls_mac and npls_div.
module nearest_point_to_line_select #(
  parameter int MAX_CANDIDATES = npls_pkg::MaxCandidates
) (
  input  logic           clk,
  input  logic           rst,
  npls_stream_if.sink    points,
  npls_stream_if.source  results,
  npls_stream_if.sink    cfg
);

  localparam int CntW = $clog2(MAX_CANDIDATES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_CANDIDATES);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DIV   = 4'b0100,
    S_CLOSE = 4'b1000
  } state_t;

  function automatic logic signed [npls_pkg::DiffW-1:0] sx(
    input logic [npls_pkg::CoordW-1:0] v
  );
    sx = $signed({v[npls_pkg::CoordW-1], v});
  endfunction

  function automatic logic [npls_pkg::DiffW-1:0] mag_of(
    input logic signed [npls_pkg::DiffW-1:0] v
  );
    mag_of = v[npls_pkg::DiffW-1] ? npls_pkg::DiffW'(-v) : npls_pkg::DiffW'(v);
  endfunction

  state_t                                 state;
  npls_pkg::op_e                          op;
  logic                                   issuing;
  logic [CntW-1:0]                        count;
  logic [npls_pkg::DistW-1:0]             run_min;
  logic [npls_pkg::IdxW-1:0]              run_index;
  logic                                   any_found;
  logic                                   out_valid;
  npls_pkg::result_t                      out_data;
  logic [npls_pkg::CoordW-1:0]            end_a [3];
  logic [npls_pkg::CoordW-1:0]            end_b [3];
  logic [npls_pkg::DistW-1:0]             threshold;
  logic                                   last_flag;
  logic signed [npls_pkg::DiffW-1:0]      u_diff [3];
  logic signed [npls_pkg::DiffW-1:0]      w_diff [3];
  logic [npls_pkg::LenW-1:0]              len_sq;
  logic [npls_pkg::MagW-1:0]              cross_mag [3];

  logic [npls_pkg::CoordW-1:0]            pt [3];
  logic signed [npls_pkg::DiffW-1:0]      line_d [3];
  logic signed [npls_pkg::DiffW-1:0]      op_x;
  logic signed [npls_pkg::DiffW-1:0]      op_y;
  logic                                   op_sub;
  logic                                   op_long;
  logic [npls_pkg::MagW-1:0]              op_sq;
  logic [npls_pkg::DiffW-1:0]             mag_x;
  logic [npls_pkg::DiffW-1:0]             mag_y;
  npls_pkg::mac_cmd_t                     mac_cmd;
  npls_pkg::mac_stat_t                    mac_st;
  logic signed [npls_pkg::AccW-1:0]       acc;
  logic signed [npls_pkg::AccW-1:0]       acc_abs;
  logic                                   div_start;
  logic                                   div_done;
  logic [npls_pkg::DistW-1:0]             div_dist;
  logic                                   pt_accept;
  logic                                   cfg_write;
  logic                                   emit;

  // Handshakes
  assign points.ready    = (state == S_IDLE);
  assign cfg.ready       = 1'b1;
  assign results.valid   = out_valid;
  assign results.payload = out_data;

  assign pt_accept = points.valid && points.ready;
  assign cfg_write = cfg.valid && cfg.ready;
  assign emit      = (state == S_CLOSE) && last_flag && (!out_valid || results.ready);

  // Candidate coordinates and line direction
  assign pt[0] = points.payload.point_x;
  assign pt[1] = points.payload.point_y;
  assign pt[2] = points.payload.point_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      line_d[i] = sx(end_a[i]) - sx(end_b[i]);
    end
  end

  // Operand selection per multiplier operation
  always_comb begin
    op_x    = '0;
    op_y    = '0;
    op_sub  = 1'b0;
    op_long = 1'b0;
    op_sq   = '0;
    unique case (op)
      npls_pkg::OpLenX:  begin op_x = line_d[0]; op_y = line_d[0]; end
      npls_pkg::OpLenY:  begin op_x = line_d[1]; op_y = line_d[1]; end
      npls_pkg::OpLenZ:  begin op_x = line_d[2]; op_y = line_d[2]; end
      npls_pkg::OpCxPos: begin op_x = u_diff[1]; op_y = w_diff[2]; end
      npls_pkg::OpCxNeg: begin op_x = u_diff[2]; op_y = w_diff[1]; op_sub = 1'b1; end
      npls_pkg::OpCyPos: begin op_x = u_diff[2]; op_y = w_diff[0]; end
      npls_pkg::OpCyNeg: begin op_x = u_diff[0]; op_y = w_diff[2]; op_sub = 1'b1; end
      npls_pkg::OpCzPos: begin op_x = u_diff[0]; op_y = w_diff[1]; end
      npls_pkg::OpCzNeg: begin op_x = u_diff[1]; op_y = w_diff[0]; op_sub = 1'b1; end
      npls_pkg::OpSqX:   begin op_long = 1'b1; op_sq = cross_mag[0]; end
      npls_pkg::OpSqY:   begin op_long = 1'b1; op_sq = cross_mag[1]; end
      npls_pkg::OpSqZ:   begin op_long = 1'b1; op_sq = cross_mag[2]; end
      default: begin end
    endcase
  end

  // Multiplier command
  assign mag_x = mag_of(op_x);
  assign mag_y = mag_of(op_y);

  always_comb begin
    mac_cmd.start = issuing && mac_st.ready;
    mac_cmd.tag   = op;
    mac_cmd.clear = op inside {npls_pkg::OpLenX, npls_pkg::OpCxPos, npls_pkg::OpCyPos,
                               npls_pkg::OpCzPos, npls_pkg::OpSqX};
    if (op_long) begin
      mac_cmd.a      = op_sq;
      mac_cmd.b      = npls_pkg::MulBW'(op_sq);
      mac_cmd.digits = npls_pkg::DigCntW'(npls_pkg::LongDigits);
      mac_cmd.neg    = 1'b0;
    end else begin
      mac_cmd.a      = npls_pkg::MagW'(mag_x);
      mac_cmd.b      = {npls_pkg::ShortBW'(mag_y),
                        {(npls_pkg::MulBW - npls_pkg::ShortBW){1'b0}}};
      mac_cmd.digits = npls_pkg::DigCntW'(npls_pkg::ShortDigits);
      mac_cmd.neg    = op_x[npls_pkg::DiffW-1] ^ op_y[npls_pkg::DiffW-1] ^ op_sub;
    end
  end

  npls_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .stat (mac_st),
    .acc  (acc)
  );

  assign acc_abs   = acc[npls_pkg::AccW-1] ? -acc : acc;
  assign div_start = mac_st.done && (mac_st.tag == npls_pkg::OpSqZ);

  npls_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc[npls_pkg::NumW-1:0]),
    .den   (len_sq),
    .done  (div_done),
    .quot  (div_dist)
  );

  // Sequencer, run state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= npls_pkg::OpLenX;
      issuing   <= 1'b0;
      count     <= '0;
      run_min   <= npls_pkg::ThresholdReset;
      run_index <= '0;
      any_found <= 1'b0;
      out_valid <= 1'b0;
      threshold <= npls_pkg::ThresholdReset;
      for (int i = 0; i < 3; i++) begin
        end_a[i] <= '0;
        end_b[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg.payload.index)
          npls_pkg::CfgEndAX:     end_a[0]  <= cfg.payload.data[npls_pkg::CoordW-1:0];
          npls_pkg::CfgEndAY:     end_a[1]  <= cfg.payload.data[npls_pkg::CoordW-1:0];
          npls_pkg::CfgEndAZ:     end_a[2]  <= cfg.payload.data[npls_pkg::CoordW-1:0];
          npls_pkg::CfgEndBX:     end_b[0]  <= cfg.payload.data[npls_pkg::CoordW-1:0];
          npls_pkg::CfgEndBY:     end_b[1]  <= cfg.payload.data[npls_pkg::CoordW-1:0];
          npls_pkg::CfgEndBZ:     end_b[2]  <= cfg.payload.data[npls_pkg::CoordW-1:0];
          npls_pkg::CfgThreshold: threshold <= cfg.payload.data[npls_pkg::DistW-1:0];
          default: begin end
        endcase
      end

      // Output register: a new result may replace one leaving in the same cycle
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end

      // Walk the operation list
      if (mac_cmd.start) begin
        if (op == npls_pkg::OpSqZ) begin
          issuing <= 1'b0;
        end else begin
          op <= npls_pkg::op_e'(op + 1'b1);
        end
      end

      unique case (state)
        S_IDLE: begin
          if (pt_accept) begin
            // run start latches the threshold
            if (count == '0) begin
              run_min   <= threshold;
              run_index <= '0;
              any_found <= 1'b0;
            end
            if (count < CntMax) begin
              state   <= S_MAC;
              issuing <= 1'b1;
              op      <= npls_pkg::OpLenX;
            end else begin
              state <= S_CLOSE;
            end
          end
        end
        S_MAC: begin
          if (div_start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_dist < run_min) begin
              run_min   <= div_dist;
              run_index <= npls_pkg::IdxW'(count);
              any_found <= 1'b1;
            end
            count <= count + 1'b1;
            state <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          if (emit) begin
            count     <= '0;
            run_index <= '0;
            any_found <= 1'b0;
            run_min   <= threshold;
            state     <= S_IDLE;
          end else if (!last_flag) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Candidate differences, intermediate sums and result
  always_ff @(posedge clk) begin
    if (pt_accept) begin
      last_flag <= points.payload.last_point;
      for (int i = 0; i < 3; i++) begin
        u_diff[i] <= sx(pt[i]) - sx(end_a[i]);
        w_diff[i] <= sx(pt[i]) - sx(end_b[i]);
      end
    end
    if (mac_st.done) begin
      case (mac_st.tag)
        npls_pkg::OpLenZ:  len_sq       <= acc[npls_pkg::LenW-1:0];
        npls_pkg::OpCxNeg: cross_mag[0] <= acc_abs[npls_pkg::MagW-1:0];
        npls_pkg::OpCyNeg: cross_mag[1] <= acc_abs[npls_pkg::MagW-1:0];
        npls_pkg::OpCzNeg: cross_mag[2] <= acc_abs[npls_pkg::MagW-1:0];
        default: begin end
      endcase
    end
    if (emit) begin
      out_data.best_index       <= any_found ? run_index : {npls_pkg::IdxW{1'b0}};
      out_data.found            <= any_found;
      out_data.best_distance_sq <= run_min;
    end
  end

  // Checks
  a_mac_start_idle: assert property (@(posedge clk) disable iff (rst)
    mac_cmd.start |-> mac_st.ready)
    else $error("multiplier started while busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_numerator_state: assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == S_MAC)
    else $error("numerator completed outside the multiply state");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= CntMax)
    else $error("candidate count beyond limit");

  a_not_found_index: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.payload.found |-> results.payload.best_index == '0)
    else $error("index reported without a winner");

endmodule
